>>> hdl/utl_pkg.sv
// Shared types, byte codes and the Cyrillic-to-CP866 mapping for the text layout block.
package utl_pkg;

	localparam logic [1:0] LEAD_NONE = 2'd0;
	localparam logic [1:0] LEAD_D0   = 2'd1;
	localparam logic [1:0] LEAD_D1   = 2'd2;

	localparam logic [7:0] BYTE_NUL  = 8'h00;
	localparam logic [7:0] BYTE_TAB  = 8'h09;
	localparam logic [7:0] BYTE_LF   = 8'h0A;
	localparam logic [7:0] BYTE_D0   = 8'hD0;
	localparam logic [7:0] BYTE_D1   = 8'hD1;
	localparam logic [7:0] CODE_QMARK = 8'h3F;

	typedef struct packed {
		logic [15:0] cursor_x;
		logic [15:0] cursor_y;
		logic [15:0] line_start_x;
		logic [1:0]  lead;
	} cursor_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic        first;
		logic        last;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
	} item_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  code;
	} draw_t;

	// CP866 code for the second byte of a two-byte sequence.
	function automatic logic [7:0] map_pair(input logic [1:0] lead, input logic [7:0] b);
		logic [7:0] code;
		code = CODE_QMARK;
		case (lead)
			LEAD_D0: begin
				if (b == 8'h81)
					code = 8'hF0;
				else if (b inside {[8'h90:8'hBF]})
					code = b - 8'h10;
			end
			LEAD_D1: begin
				if (b == 8'h91)
					code = 8'hF1;
				else if (b inside {[8'h80:8'h8F]})
					code = b + 8'h60;
			end
			default: code = CODE_QMARK;
		endcase
		return code;
	endfunction

endpackage

>>> hdl/utl_decode.sv
// Combinational byte decode: next cursor state and optional draw command.
module utl_decode #(
	parameter int GLYPH_WIDTH  = 8,
	parameter int GLYPH_HEIGHT = 16
) (
	input  utl_pkg::cursor_t cur,
	input  utl_pkg::item_t   item,
	output utl_pkg::cursor_t nxt,
	output logic             emit,
	output utl_pkg::draw_t   draw
);

	localparam logic [15:0] STEP_X = 16'(GLYPH_WIDTH);
	localparam logic [15:0] STEP_Y = 16'(GLYPH_HEIGHT);
	localparam logic [15:0] TAB_X  = 16'(4 * GLYPH_WIDTH);

	utl_pkg::cursor_t base;
	logic [7:0]       b;

	always_comb begin
		base = cur;
		if (item.first) begin
			base.cursor_x     = item.origin_x;
			base.cursor_y     = item.origin_y;
			base.line_start_x = item.origin_x;
			base.lead         = utl_pkg::LEAD_NONE;
		end
		b = item.byte_value;

		nxt       = base;
		emit      = 1'b0;
		draw.x    = base.cursor_x;
		draw.y    = base.cursor_y;
		draw.code = b;

		if (base.lead != utl_pkg::LEAD_NONE) begin
			// second byte of a pair: any nonzero value draws
			nxt.lead = utl_pkg::LEAD_NONE;
			if (b != utl_pkg::BYTE_NUL) begin
				emit         = 1'b1;
				draw.code    = utl_pkg::map_pair(base.lead, b);
				nxt.cursor_x = base.cursor_x + STEP_X;
			end
		end else if (b == utl_pkg::BYTE_NUL) begin
			nxt = base;
		end else if (b == utl_pkg::BYTE_LF) begin
			nxt.cursor_x = base.line_start_x;
			nxt.cursor_y = base.cursor_y + STEP_Y;
		end else if (b == utl_pkg::BYTE_TAB) begin
			nxt.cursor_x = base.cursor_x + TAB_X;
		end else if (!b[7]) begin
			emit         = 1'b1;
			nxt.cursor_x = base.cursor_x + STEP_X;
		end else if ((b == utl_pkg::BYTE_D0 || b == utl_pkg::BYTE_D1) && !item.last) begin
			nxt.lead = (b == utl_pkg::BYTE_D0) ? utl_pkg::LEAD_D0 : utl_pkg::LEAD_D1;
		end
	end

endmodule

>>> hdl/utf8_cyrillic_text_layout.sv
// Top level: input register, cursor state, byte decode and draw command register.
//
// Takes one UTF-8 byte per clock while in_stall is low, and produces zero or one glyph
// draw command per byte. A byte is registered on acceptance and decoded in the following
// cycle against the cursor registers; its draw command (if any) is loaded into the output
// register when the byte advances, which a held output can delay. Throughput is one byte
// every cycle while in_stall is low, set by the update of the cursor and pending lead
// registers directly through the decode logic. Bytes that draw nothing (zero, newline, tab,
// lead bytes, skipped high bytes) never wait on out_stall; a drawing byte waits only while
// a previous command is still held on the output.
module utf8_cyrillic_text_layout #(
	parameter int GLYPH_WIDTH  = 8,
	parameter int GLYPH_HEIGHT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         byte_value,
	input  logic               first,
	input  logic               last,
	input  logic signed [15:0] origin_x,
	input  logic signed [15:0] origin_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] draw_x,
	output logic signed [15:0] draw_y,
	output logic [7:0]         glyph_code
);

	logic             valid_s1;
	utl_pkg::item_t   item_s1;
	utl_pkg::cursor_t cur_q;
	utl_pkg::cursor_t cur_nxt;
	logic             emit;
	utl_pkg::draw_t   draw_nxt;
	logic             out_valid_q;
	utl_pkg::draw_t   draw_q;
	logic             adv;

	utl_decode #(
		.GLYPH_WIDTH (GLYPH_WIDTH),
		.GLYPH_HEIGHT(GLYPH_HEIGHT)
	) u_decode (
		.cur (cur_q),
		.item(item_s1),
		.nxt (cur_nxt),
		.emit(emit),
		.draw(draw_nxt)
	);

	// advance the held byte unless it draws and the output is still occupied
	assign adv      = valid_s1 && (!emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.byte_value <= byte_value;
			item_s1.first      <= first;
			item_s1.last       <= last;
			item_s1.origin_x   <= origin_x;
			item_s1.origin_y   <= origin_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.cursor_x     <= '0;
			cur_q.cursor_y     <= '0;
			cur_q.line_start_x <= '0;
			cur_q.lead         <= utl_pkg::LEAD_NONE;
		end else if (adv) begin
			cur_q <= cur_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			draw_q <= draw_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign draw_x     = draw_q.x;
	assign draw_y     = draw_q.y;
	assign glyph_code = draw_q.code;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(item_s1))
		else $error("held byte changed while stalled");

	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |=> out_valid)
		else $error("draw transaction lost");

	a_last_no_lead: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.last |=> cur_q.lead == utl_pkg::LEAD_NONE)
		else $error("lead held after last byte");

endmodule
